/* rtl/core/fmmm_pkg.sv */
// fmmm_pkg: shared widths, status codes and kind codes for the fifo statistics unit
// no dependencies; used by fmmm_div, fifo_with_min_max_mean_unit and its testbench
package fmmm_pkg;

    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;

    typedef logic [STATUS_W-1:0] status_t;

    localparam status_t STATUS_OK    = 2'd0;
    localparam status_t STATUS_EMPTY = 2'd1;
    localparam status_t STATUS_FULL  = 2'd2;

    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

endpackage

/* rtl/core/fmmm_div.sv */
// fmmm_div: restoring unsigned divider, one quotient bit per cycle
// depends on fmmm_pkg for the quotient width
module fmmm_div #(
    parameter int DIVIDEND_W = 37,
    parameter int DIVISOR_W  = 5
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [DIVIDEND_W-1:0]         dividend,
    input  logic [DIVISOR_W-1:0]          divisor,
    output logic                          done,
    output logic [fmmm_pkg::VALUE_W-1:0]  quotient
);

    localparam int STEP_W = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIVISOR_W:0]    rem_shift;
    logic                  fits;

    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[DIVIDEND_W-1]};
        fits      = rem_shift >= {1'b0, divisor};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            step_next = STEP_W'(DIVIDEND_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // remainder stays below the divisor, so it fits the divisor width
            rem_next  = fits ? DIVISOR_W'(rem_shift - {1'b0, divisor})
                             : rem_shift[DIVISOR_W-1:0];
            quo_next  = {quo_reg[DIVIDEND_W-2:0], fits};
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg[fmmm_pkg::VALUE_W-1:0];

endmodule

/* rtl/core/fifo_with_min_max_mean_unit.sv */
// channel  | direction | tdata                          | tuser
// s_*      | in        | value                          | kind (0 push, 1 pop)
// m_*      | out       | status, entry_count, largest,  | -
//          |           | smallest, average (low first)  |
//
// one word at a time: accept, a memory read for each held entry in ST_SCAN,
// ST_DIVGO starts the divider on the SUM_W-bit sum (SUM_W = 33 + log2 DEPTH),
// ST_DIV waits for the quotient, ST_OUT holds the result, then the next
// accept; a word that leaves the queue empty goes straight to the output
// s_tready is high only when the unit is idle; the result waits in the output
// register until m_tready; reset empties the queue at once
// fifo_with_min_max_mean_unit: bounded fifo with running max, min and mean
// depends on fmmm_pkg and fmmm_div
module fifo_with_min_max_mean_unit #(
    parameter int DEPTH = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,    // value
    input  logic         s_tuser,    // kind
    output logic         m_tvalid,
    input  logic         m_tready,
    // status, entry_count, largest, smallest, average, zero pad
    output logic [((fmmm_pkg::STATUS_W + $clog2(DEPTH + 1) + 3 * fmmm_pkg::VALUE_W + 7) / 8) * 8 - 1:0]
                         m_tdata
);

    localparam int VW     = fmmm_pkg::VALUE_W;
    localparam int AW     = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SUM_W  = VW + AW + 1;
    localparam int OUT_W  = ((fmmm_pkg::STATUS_W + CNT_W + 3 * VW + 7) / 8) * 8;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_DIVGO = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    logic [VW-1:0] mem [DEPTH];

    logic [2:0]              state_reg, state_next;
    logic [AW-1:0]           head_reg, head_next;
    logic [AW-1:0]           tail_reg, tail_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [AW-1:0]           rd_addr_reg, rd_addr_next;
    logic [CNT_W-1:0]        issued_reg, issued_next;
    logic [CNT_W-1:0]        got_reg, got_next;
    logic                    rd_pend_reg, rd_pend_next;
    logic signed [VW-1:0]    rd_data_reg;
    logic signed [VW-1:0]    hi_reg, hi_next;
    logic signed [VW-1:0]    lo_reg, lo_next;
    logic signed [VW-1:0]    avg_reg, avg_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    fmmm_pkg::status_t       status_reg, status_next;

    logic                    accept;
    logic                    wr_en;
    logic                    rd_en;
    logic                    first;
    logic signed [SUM_W-1:0] v_ext;
    logic [SUM_W-1:0]        sum_mag;
    logic                    div_start;
    logic                    div_done;
    logic [VW-1:0]           div_quo;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] idx);
        logic [AW-1:0] res;
        res = (idx == AW'(DEPTH - 1)) ? '0 : idx + 1'b1;
        return res;
    endfunction

    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = (state_reg == ST_OUT);
    assign accept    = s_tvalid && s_tready;
    assign wr_en     = accept && (s_tuser == fmmm_pkg::KIND_PUSH)
                       && (cnt_reg != CNT_W'(DEPTH));
    assign rd_en     = (state_reg == ST_SCAN) && (issued_reg != cnt_reg);
    assign first     = (got_reg == '0);
    assign v_ext     = {{(SUM_W - VW){rd_data_reg[VW-1]}}, rd_data_reg};
    assign sum_mag   = sum_reg[SUM_W-1] ? (~sum_reg + 1'b1) : sum_reg;
    assign div_start = (state_reg == ST_DIVGO);

    always_comb
    begin
        state_next   = state_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        cnt_next     = cnt_reg;
        rd_addr_next = rd_addr_reg;
        issued_next  = issued_reg;
        got_next     = got_reg;
        rd_pend_next = 1'b0;
        hi_next      = hi_reg;
        lo_next      = lo_reg;
        avg_next     = avg_reg;
        sum_next     = sum_reg;
        status_next  = status_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    status_next = fmmm_pkg::STATUS_OK;
                    if (s_tuser == fmmm_pkg::KIND_PUSH)
                    begin
                        if (cnt_reg == CNT_W'(DEPTH))
                        begin
                            status_next = fmmm_pkg::STATUS_FULL;
                        end
                        else
                        begin
                            tail_next = wrap_inc(tail_reg);
                            cnt_next  = cnt_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        if (cnt_reg == '0)
                        begin
                            status_next = fmmm_pkg::STATUS_EMPTY;
                        end
                        else
                        begin
                            head_next = wrap_inc(head_reg);
                            cnt_next  = cnt_reg - 1'b1;
                        end
                    end
                    rd_addr_next = head_next;
                    issued_next  = '0;
                    got_next     = '0;
                    hi_next      = '0;
                    lo_next      = '0;
                    avg_next     = '0;
                    sum_next     = '0;
                    // nothing held: statistics stay zero
                    state_next   = (cnt_next == '0) ? ST_OUT : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (rd_en)
                begin
                    rd_addr_next = wrap_inc(rd_addr_reg);
                    issued_next  = issued_reg + 1'b1;
                    rd_pend_next = 1'b1;
                end
                if (rd_pend_reg)
                begin
                    hi_next  = (first || rd_data_reg > hi_reg) ? rd_data_reg : hi_reg;
                    lo_next  = (first || rd_data_reg < lo_reg) ? rd_data_reg : lo_reg;
                    sum_next = first ? v_ext : sum_reg + v_ext;
                    got_next = got_reg + 1'b1;
                    if (got_reg + 1'b1 == cnt_reg)
                    begin
                        state_next = ST_DIVGO;
                    end
                end
            end
            ST_DIVGO:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    // divide the magnitude, then restore the sign of the sum
                    avg_next   = sum_reg[SUM_W-1] ? (~div_quo + 1'b1) : div_quo;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            head_reg    <= '0;
            tail_reg    <= '0;
            cnt_reg     <= '0;
            rd_pend_reg <= 1'b0;
            issued_reg  <= '0;
            got_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            cnt_reg     <= cnt_next;
            rd_pend_reg <= rd_pend_next;
            issued_reg  <= issued_next;
            got_reg     <= got_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_addr_reg <= rd_addr_next;
        hi_reg      <= hi_next;
        lo_reg      <= lo_next;
        avg_reg     <= avg_next;
        sum_reg     <= sum_next;
        status_reg  <= status_next;
    end

    // entry memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[tail_reg] <= s_tdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr_reg];
        end
    end

    fmmm_div #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_mag),
        .divisor  (cnt_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign m_tdata = OUT_W'({avg_reg, lo_reg, hi_reg, cnt_reg, status_reg});

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready)
        else $error("input taken while a result is pending");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && status_reg == fmmm_pkg::STATUS_FULL) |-> (cnt_reg == CNT_W'(DEPTH)))
        else $error("full status with room left");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && cnt_reg == '0) |-> (hi_reg == '0 && lo_reg == '0 && avg_reg == '0))
        else $error("statistics not zero on empty queue");

endmodule

/* test/fifo_with_min_max_mean_unit_tb.sv */
// fifo_with_min_max_mean_unit_tb: pushes and pops signed words through the unit and
// checks status, count, max, min and mean of each result word against a local queue model
// depends on fmmm_pkg and fifo_with_min_max_mean_unit
module fifo_with_min_max_mean_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH      = 16;
    localparam int VALUE_W    = fmmm_pkg::VALUE_W;
    localparam int STATUS_W   = fmmm_pkg::STATUS_W;
    localparam int COUNT_W    = $clog2(DEPTH + 1);
    localparam int RESULT_W   = ((STATUS_W + COUNT_W + 3 * VALUE_W + 7) / 8) * 8;
    localparam int ITEMS      = 1950;
    localparam int IDLE_LIMIT = 2000;
    localparam int TAIL_WAIT  = 80;

    typedef struct packed {
        fmmm_pkg::status_t          status;
        logic [COUNT_W-1:0]         entry_count;
        logic signed [VALUE_W-1:0]  largest;
        logic signed [VALUE_W-1:0]  smallest;
        logic signed [VALUE_W-1:0]  average;
    } stats_word_t;

    class fifo_stats_board;
        logic signed [VALUE_W-1:0] slots[DEPTH];
        int          head;
        int          tail;
        int          held;
        stats_word_t pending_stats[$];
        int          errors;

        function new();
            head   = 0;
            tail   = 0;
            held   = 0;
            errors = 0;
        endfunction

        task report(string msg);
            $display("tb: mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        // apply one accepted word to the queue model and queue the stats it should produce
        function void note_input(logic kind, logic signed [VALUE_W-1:0] value);
            stats_word_t w;
            longint      total;
            int          idx;
            w.status = fmmm_pkg::STATUS_OK;
            if (kind == fmmm_pkg::KIND_PUSH)
            begin
                if (held == DEPTH)
                    w.status = fmmm_pkg::STATUS_FULL;
                else
                begin
                    slots[tail] = value;
                    tail = (tail + 1) % DEPTH;
                    held++;
                end
            end
            else
            begin
                if (held == 0)
                    w.status = fmmm_pkg::STATUS_EMPTY;
                else
                begin
                    head = (head + 1) % DEPTH;
                    held--;
                end
            end
            w.entry_count = held[COUNT_W-1:0];
            w.largest     = '0;
            w.smallest    = '0;
            w.average     = '0;
            if (held > 0)
            begin
                total      = 0;
                w.largest  = slots[head];
                w.smallest = slots[head];
                for (int n = 0; n < held; n++)
                begin
                    idx = (head + n) % DEPTH;
                    if (slots[idx] > w.largest)
                        w.largest = slots[idx];
                    if (slots[idx] < w.smallest)
                        w.smallest = slots[idx];
                    total += slots[idx];
                end
                // signed longint division truncates toward zero
                w.average = VALUE_W'(total / held);
            end
            pending_stats.push_back(w);
        endfunction

        task check_result(logic [RESULT_W-1:0] word);
            stats_word_t got;
            stats_word_t want;
            got.status      = word[STATUS_W-1:0];
            got.entry_count = word[STATUS_W +: COUNT_W];
            got.largest     = word[STATUS_W + COUNT_W +: VALUE_W];
            got.smallest    = word[STATUS_W + COUNT_W + VALUE_W +: VALUE_W];
            got.average     = word[STATUS_W + COUNT_W + 2 * VALUE_W +: VALUE_W];
            if (pending_stats.size() == 0)
            begin
                report("result word with nothing expected");
                return;
            end
            want = pending_stats.pop_front();
            if (got.status !== want.status)
                report($sformatf("status %0d, want %0d", got.status, want.status));
            if (got.entry_count !== want.entry_count)
                report($sformatf("count %0d, want %0d", got.entry_count, want.entry_count));
            if (got.largest !== want.largest)
                report($sformatf("largest %0d, want %0d", got.largest, want.largest));
            if (got.smallest !== want.smallest)
                report($sformatf("smallest %0d, want %0d", got.smallest, want.smallest));
            if (got.average !== want.average)
                report($sformatf("average %0d, want %0d", got.average, want.average));
        endtask
    endclass

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [31:0]          s_tdata  = '0;    // value
    logic                 s_tuser  = 1'b0;  // kind
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [RESULT_W-1:0]  m_tdata;          // status, entry_count, largest, smallest, average

    fifo_stats_board board = new();

    int idle_cycles = 0;
    int ready_mode  = 0;
    int stall_left  = 0;
    int cycle_count = 0;
    int push_pct    = 50;
    int sent        = 0;

    fifo_with_min_max_mean_unit #(
        .DEPTH(DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // receiver: always ready, coin-flip ready, or long stalls, in a mode picked at random
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count % 256 == 0)
            ready_mode <= $urandom_range(0, 2);
        if (rst_n && m_tvalid && m_tready)
            board.check_result(m_tdata);
        if (stall_left != 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (ready_mode == 0)
            m_tready <= 1'b1;
        else if (ready_mode == 1)
            m_tready <= $urandom_range(0, 1);
        else
        begin
            m_tready   <= 1'b1;
            stall_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : 0;
        end
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_word(input logic kind, input logic signed [31:0] value);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= value;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        board.note_input(kind, value);
        sent++;
    endtask

    task automatic pause_sender(input int cycles);
        s_tvalid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'sh7fff_ffff;
            1:       return 32'sh8000_0000;
            2:       return '0;
            3:       return -32'sd1;
            4, 5:    return $signed($urandom_range(0, 16)) - 32'sd8;
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        int burst;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty pop, extremes, mean rounding toward zero, fill to full and refuse
        send_word(fmmm_pkg::KIND_POP, 32'sd0);
        send_word(fmmm_pkg::KIND_PUSH, 32'sh7fff_ffff);
        send_word(fmmm_pkg::KIND_PUSH, 32'sh8000_0000);
        send_word(fmmm_pkg::KIND_PUSH, -32'sd3);
        send_word(fmmm_pkg::KIND_POP, 32'sd0);
        send_word(fmmm_pkg::KIND_POP, 32'sd0);
        for (int i = 0; i < DEPTH - 1; i++)
            send_word(fmmm_pkg::KIND_PUSH, (i % 2 == 0) ? 32'sh8000_0000 : 32'sh7fff_ffff);
        send_word(fmmm_pkg::KIND_PUSH, 32'sh5555_aaaa);
        send_word(fmmm_pkg::KIND_POP, 32'sd0);
        send_word(fmmm_pkg::KIND_PUSH, 32'sh0000_0001);

        // random bursts, push bias changing so the queue swings between empty and full
        while (sent < ITEMS)
        begin
            if ($urandom_range(0, 47) == 0)
                push_pct = ($urandom_range(0, 2) == 0) ? 15
                         : (($urandom_range(0, 1) == 0) ? 50 : 85);
            burst = $urandom_range(1, 12);
            for (int i = 0; i < burst; i++)
            begin
                if ($urandom_range(0, 99) < push_pct)
                    send_word(fmmm_pkg::KIND_PUSH, pick_value());
                else
                    send_word(fmmm_pkg::KIND_POP, $urandom);
            end
            if ($urandom_range(0, 3) != 0)
                pause_sender($urandom_range(1, 70));
        end
        s_tvalid <= 1'b0;

        while (board.pending_stats.size() != 0)
            @(posedge clk);
        repeat (TAIL_WAIT) @(posedge clk);
        if (board.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
